@@ src/swlm_pkg.sv @@
// Shared types and constants of the sequence window loss meter.
`timescale 1ns / 1ps
package swlm_pkg;

	localparam int MAX_PKTS   = 1024;
	localparam int MAP_ROW_W  = 32;
	localparam int MAP_ROWS   = MAX_PKTS / MAP_ROW_W;
	localparam int MAP_RAW    = $clog2(MAP_ROWS);
	localparam int MAP_BW     = $clog2(MAP_ROW_W);
	localparam int HIST_DEPTH = 64;
	localparam int HIST_AW    = $clog2(HIST_DEPTH);

	localparam int N_W        = 11;
	localparam int SEC_W      = 16;
	localparam int WIN_W      = 7;
	localparam int SERIAL_W   = 31;
	localparam int PCT_W      = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

	typedef enum logic [1:0] {
		CMD_PKT    = 2'd0,
		CMD_TICK   = 2'd1,
		CMD_RECENT = 2'd2,
		CMD_AVG    = 2'd3
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PKTS_PER_PERIOD = 2'd0,
		CFG_PERIOD_SECONDS  = 2'd1,
		CFG_WINDOW_PERIODS  = 2'd2
	} cfg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PKT_CHECK,
		S_PKT_FIRST,
		S_PKT_MAP,
		S_PKT_MARK,
		S_TICK,
		S_WIN_INIT,
		S_WIN_SUM,
		S_AVG,
		S_CMP,
		S_X100A,
		S_X100B,
		S_DIV,
		S_OUT
	} state_t;

endpackage

@@ src/swlm_ifs.sv @@
// Request and result channel interfaces of the loss meter.
`timescale 1ns / 1ps
interface swlm_req_if;
	logic                               valid;
	logic                               ready;
	swlm_pkg::cmd_t                     command;
	logic [swlm_pkg::SERIAL_W-1:0]      serial;

	modport source(output valid, command, serial, input ready);
	modport sink(input valid, command, serial, output ready);
endinterface

interface swlm_res_if;
	logic                               valid;
	logic                               ready;
	logic [swlm_pkg::PCT_W-1:0]         loss_percent;
	logic                               is_average;

	modport source(output valid, loss_percent, is_average, input ready);
	modport sink(input valid, loss_percent, is_average, output ready);
endinterface

@@ src/sequence_window_loss_meter_unit.sv @@
// Top level of the sequence window loss meter: sequencer, shared datapath and memories.
//
// Usage: requests arrive on req (command, serial); command 0 reports a packet,
// 1 a one-second tick, 2 asks for the loss over the last window_periods periods,
// 3 for the loss over all periods. Commands 2 and 3 return one result on res
// (loss_percent, is_average); commands 0 and 1 return nothing.
// Configuration is written through cfg_we / cfg_index / cfg_data while idle.
// One request is worked at a time; req.ready is high only in the idle state.
// Packets that open a new period also form that period's first serial; a packet whose
// serial falls in the open period is also marked in the bitmap.
// The recent query's work grows with the number of window periods.
// Queries loop one 56-bit add/subtract unit: two adds for the x100 scaling and a
// seven-step restoring division; the recent query first reads the loss ring one
// entry a cycle. A single 33x11 multiplier forms period totals and first serials.
// The result lands in an output register, so a new request is taken while it
// waits; a query finishing while that register is still full holds until res.ready.
// Reset clears the received bitmap through its row valid bits at once; no
// clearing pass is needed. Configuration returns to 1024 / 1 / 4.
module sequence_window_loss_meter_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [swlm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [swlm_pkg::CFG_DATA_W-1:0]      cfg_data,
	swlm_req_if.sink                             req,
	swlm_res_if.source                           res
);
	import swlm_pkg::*;

	// configuration
	logic [N_W-1:0]   ppp_q;
	logic [SEC_W-1:0] psec_q;
	logic [WIN_W-1:0] wper_q;

	// control
	state_t state_q, state_d;

	// block state
	logic                started_q;
	logic [SEC_W-1:0]    elapsed_q;
	logic [31:0]         pc_q;
	logic [31:0]         pfs_q;
	logic [N_W-1:0]      rd_q;
	logic [N_W-1:0]      arr_q;
	logic [47:0]         all_sum_q;
	logic [MAP_ROWS-1:0] row_vld_q;

	// request and work registers
	cmd_t                cmd_q;
	logic [SERIAL_W-1:0] serial_q;
	logic [9:0]          off_q;
	logic [WIN_W-1:0]    idx_q;
	logic                pend_q;
	logic [16:0]         acc_q;
	logic [48:0]         num_q;
	logic [43:0]         den_q;
	logic [55:0]         rem_q;
	logic [2:0]          step_q;
	logic [PCT_W-1:0]    pct_q;

	// result register
	logic                out_vld_q;
	logic [PCT_W-1:0]    out_pct_q;
	logic                out_avg_q;

	// memories
	logic [MAP_ROW_W-1:0] map_mem [MAP_ROWS];
	logic [MAP_ROW_W-1:0] map_rdata_q;
	logic [MAP_RAW-1:0]   map_raddr;
	logic [N_W-1:0]       ring_mem [HIST_DEPTH];
	logic [N_W-1:0]       ring_rdata_q;
	logic [HIST_AW-1:0]   ring_raddr;

	// shared units
	logic [32:0] mul_a;
	logic [10:0] mul_b;
	logic [43:0] mul_p;
	logic [55:0] au_a, au_b;
	logic        au_sub;
	logic [56:0] au_sum;
	logic        au_carry;

	// derived values
	logic [N_W-1:0]      eff_n;
	logic [N_W-1:0]      open_loss;
	logic [SEC_W-1:0]    ps_eff;
	logic [WIN_W-1:0]    k_eff;
	logic [32:0]         exists;
	logic                close_now;
	logic                arr_ok;
	logic [32:0]         ser_ext, pfs_ext, diff;
	logic                in_range;
	logic [MAP_ROW_W-1:0] row_word;
	logic                bit_new;
	logic                win_ok;
	logic                idx_live;
	logic                sum_done;
	logic                out_free;
	logic [55:0]         den_sh;

	always_comb begin
		if (ppp_q == '0) begin
			eff_n = N_W'(1);
		end else if (ppp_q > N_W'(MAX_PKTS)) begin
			eff_n = N_W'(MAX_PKTS);
		end else begin
			eff_n = ppp_q;
		end
	end

	assign open_loss = (rd_q >= eff_n) ? '0 : eff_n - rd_q;
	assign ps_eff    = (psec_q == '0) ? SEC_W'(1) : psec_q;
	assign k_eff     = (wper_q > WIN_W'(HIST_DEPTH)) ? WIN_W'(HIST_DEPTH) : wper_q;
	assign exists    = started_q ? {1'b0, pc_q} + 33'd1 : '0;
	assign close_now = elapsed_q >= ps_eff;
	assign arr_ok    = arr_q < eff_n;
	assign ser_ext   = {2'b0, serial_q};
	assign pfs_ext   = {1'b0, pfs_q};
	assign diff      = ser_ext - pfs_ext;
	assign in_range  = (ser_ext >= pfs_ext) && (diff < {22'b0, eff_n});
	assign row_word  = row_vld_q[off_q[9:5]] ? map_rdata_q : '0;
	assign bit_new   = !row_word[off_q[4:0]];
	assign win_ok    = (k_eff != '0) && (exists >= {26'b0, k_eff});
	assign idx_live  = idx_q < k_eff;
	assign sum_done  = !idx_live && !pend_q;
	assign out_free  = !out_vld_q || res.ready;
	assign den_sh    = {12'b0, den_q} << step_q;

	assign mul_p    = mul_a * mul_b;
	assign au_sum   = {1'b0, au_a} + {1'b0, (au_sub ? ~au_b : au_b)} + 57'(au_sub);
	assign au_carry = au_sum[56];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					unique case (req.command)
						CMD_PKT:    state_d = S_PKT_CHECK;
						CMD_TICK:   state_d = S_TICK;
						CMD_RECENT: state_d = S_WIN_INIT;
						CMD_AVG:    state_d = S_AVG;
					endcase
				end
			end
			S_PKT_CHECK: state_d = close_now ? S_PKT_FIRST : S_PKT_MAP;
			S_PKT_FIRST: state_d = S_PKT_MAP;
			S_PKT_MAP:   state_d = (arr_ok && in_range) ? S_PKT_MARK : S_IDLE;
			S_PKT_MARK:  state_d = S_IDLE;
			S_TICK:      state_d = S_IDLE;
			S_WIN_INIT:  state_d = win_ok ? S_WIN_SUM : S_OUT;
			S_WIN_SUM:   state_d = sum_done ? S_CMP : S_WIN_SUM;
			S_AVG:       state_d = started_q ? S_CMP : S_OUT;
			S_CMP:       state_d = au_carry ? S_OUT : S_X100A;
			S_X100A:     state_d = S_X100B;
			S_X100B:     state_d = S_DIV;
			S_DIV:       state_d = (step_q == '0) ? S_OUT : S_DIV;
			S_OUT:       state_d = out_free ? S_IDLE : S_OUT;
			default:     state_d = S_IDLE;
		endcase
	end

	// unit operands and handshake
	always_comb begin
		req.ready  = 1'b0;
		mul_a      = '0;
		mul_b      = eff_n;
		au_a       = '0;
		au_b       = '0;
		au_sub     = 1'b0;
		map_raddr  = diff[9:5];
		ring_raddr = pc_q[HIST_AW-1:0] - idx_q[HIST_AW-1:0];
		unique case (state_q)
			S_IDLE:      req.ready = 1'b1;
			S_PKT_FIRST: mul_a = {1'b0, pc_q};
			S_WIN_INIT:  mul_a = {26'b0, k_eff};
			S_AVG:       mul_a = {1'b0, pc_q} + 33'd1;
			S_CMP: begin
				au_a   = {7'b0, num_q};
				au_b   = {12'b0, den_q};
				au_sub = 1'b1;
			end
			S_X100A: begin
				au_a = {1'b0, num_q, 6'b0};
				au_b = {2'b0, num_q, 5'b0};
			end
			S_X100B: begin
				au_a = rem_q;
				au_b = {5'b0, num_q, 2'b0};
			end
			S_DIV: begin
				au_a   = rem_q;
				au_b   = den_sh;
				au_sub = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppp_q  <= N_W'(MAX_PKTS);
			psec_q <= SEC_W'(1);
			wper_q <= WIN_W'(4);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PKTS_PER_PERIOD: ppp_q  <= cfg_data[N_W-1:0];
				CFG_PERIOD_SECONDS:  psec_q <= cfg_data[SEC_W-1:0];
				CFG_WINDOW_PERIODS:  wper_q <= cfg_data[WIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			started_q <= 1'b0;
			elapsed_q <= '0;
			pc_q      <= '0;
			pfs_q     <= '0;
			rd_q      <= '0;
			arr_q     <= '0;
			all_sum_q <= '0;
			row_vld_q <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_OUT && out_free) begin
				out_vld_q <= 1'b1;
			end else if (res.ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_PKT_CHECK: begin
					started_q <= 1'b1;
					if (close_now) begin
						all_sum_q <= all_sum_q + 48'(open_loss);
						pc_q      <= pc_q + 32'd1;
						row_vld_q <= '0;
						rd_q      <= '0;
						arr_q     <= '0;
						elapsed_q <= '0;
					end
				end
				S_PKT_FIRST: pfs_q <= (mul_p[43:32] != '0) ? '1 : mul_p[31:0];
				S_PKT_MAP: begin
					if (arr_ok) begin
						arr_q <= arr_q + N_W'(1);
					end
				end
				S_PKT_MARK: begin
					if (bit_new) begin
						row_vld_q[off_q[9:5]] <= 1'b1;
						rd_q <= rd_q + N_W'(1);
					end
				end
				S_TICK: begin
					if (started_q && elapsed_q != '1) begin
						elapsed_q <= elapsed_q + SEC_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// payload and work registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				cmd_q    <= req.command;
				serial_q <= req.serial;
			end
			S_PKT_MAP:  off_q <= diff[9:0];
			S_WIN_INIT: begin
				den_q  <= mul_p;
				idx_q  <= WIN_W'(1);
				pend_q <= 1'b0;
				acc_q  <= '0;
				pct_q  <= '0;
			end
			S_WIN_SUM: begin
				if (idx_live) begin
					idx_q <= idx_q + WIN_W'(1);
				end
				pend_q <= idx_live;
				if (pend_q) begin
					acc_q <= acc_q + 17'(ring_rdata_q);
				end
				num_q <= 49'(acc_q) + 49'(open_loss);
			end
			S_AVG: begin
				den_q <= mul_p;
				num_q <= 49'(all_sum_q) + 49'(open_loss);
				pct_q <= '0;
			end
			S_CMP:   pct_q <= au_carry ? PCT_FULL : '0;
			S_X100A: rem_q <= au_sum[55:0];
			S_X100B: begin
				rem_q  <= au_sum[55:0];
				step_q <= 3'd6;
			end
			S_DIV: begin
				if (au_carry) begin
					rem_q         <= au_sum[55:0];
					pct_q[step_q] <= 1'b1;
				end
				step_q <= step_q - 3'd1;
			end
			S_OUT: begin
				if (out_free) begin
					out_pct_q <= pct_q;
					out_avg_q <= (cmd_q == CMD_AVG);
				end
			end
			default: ;
		endcase
	end

	// received bitmap rows
	always_ff @(posedge clk) begin
		map_rdata_q <= map_mem[map_raddr];
		if (state_q == S_PKT_MARK && bit_new) begin
			map_mem[off_q[9:5]] <= row_word | (MAP_ROW_W'(1) << off_q[4:0]);
		end
	end

	// closed period loss ring
	always_ff @(posedge clk) begin
		ring_rdata_q <= ring_mem[ring_raddr];
		if (state_q == S_PKT_CHECK && close_now) begin
			ring_mem[pc_q[HIST_AW-1:0]] <= open_loss;
		end
	end

	assign res.valid        = out_vld_q;
	assign res.loss_percent = out_pct_q;
	assign res.is_average   = out_avg_q;

	a_distinct_le_arrivals: assert property (@(posedge clk) disable iff (!arst_n)
		rd_q <= arr_q)
		else $error("distinct count exceeds arrivals");

	a_result_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(state_q == S_OUT))
		else $error("result raised outside output state");

	a_pct_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> out_pct_q <= PCT_FULL)
		else $error("loss percent above 100");

	a_close_clears_clock: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q != $past(pc_q) |-> (elapsed_q == '0 && rd_q == '0 && row_vld_q == '0))
		else $error("period change did not restart period state");

	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> rem_q < ({12'b0, den_q} << 7))
		else $error("division remainder out of range");

endmodule
